/* hdl/iphc_pkg.sv */
package iphc_pkg;

    // Header geometry
    localparam int unsigned MAX_HEADER_BYTES = 60;
    localparam int unsigned BASE_HEADER      = 20;
    localparam int unsigned HDR_IDX_W        = $clog2(BASE_HEADER);

    localparam logic [3:0] IPV4_VER_CODE = 4'd4;

    // Byte positions inside the fixed header
    localparam logic [15:0] POS_VER_IHL  = 16'd0;
    localparam logic [15:0] POS_TLEN_LO  = 16'd3;
    localparam logic [15:0] POS_CSUM_HI  = 16'd10;
    localparam logic [15:0] POS_CSUM_LO  = 16'd11;
    localparam int unsigned POS_TLEN_HI  = 2;
    localparam int unsigned POS_PROTO    = 9;
    localparam int unsigned POS_SRC      = 12;
    localparam int unsigned POS_DST      = 16;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes
    localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
    localparam logic [2:0] VERDICT_SHORT    = 3'd1;
    localparam logic [2:0] VERDICT_BAD_HDR  = 3'd2;
    localparam logic [2:0] VERDICT_BAD_CSUM = 3'd3;
    localparam logic [2:0] VERDICT_NOT_OURS = 3'd4;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  verdict;
        logic [7:0]  upper_protocol;
        logic [31:0] source_address;
        logic        end_of_run;
    } t_out_item;

endpackage

/* hdl/ipv4_receive_header_checker.sv */
// Channel   | Dir | Handshake                   | Item
// ----------+-----+-----------------------------+---------------------------------
// in        | in  | i_in_valid / o_in_ready     | iphc_pkg::t_in_item (one byte)
// out       | out | o_out_valid / i_out_ready   | iphc_pkg::t_out_item (payload or verdict)
// cfg       | in  | i_cfg_valid / o_cfg_ready   | 32-bit local address
//
// Each accepted byte updates the header state in its accept cycle, and its results
// enter a four-entry result queue, visible in the next cycle. Input is ready while
// the queue holds two or fewer items, so bytes stream back to back while the sink
// takes an item per cycle; the last byte may push two items.
// Reset (i_rst_n low, synchronous) clears the packet state (not the stored header
// bytes), the local address and the queue. The config port is always ready.
module ipv4_receive_header_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iphc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iphc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // Packet state
    logic [15:0] r_byte_count, n_byte_count;
    logic [5:0]  r_hdr_len, n_hdr_len;
    logic [15:0] r_total_len, n_total_len;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_csum, n_csum;
    logic [7:0]  r_hold, n_hold;
    logic [7:0]  r_hdr [iphc_pkg::BASE_HEADER];
    logic [7:0]  n_hdr [iphc_pkg::BASE_HEADER];
    logic [31:0] r_local_addr;

    // Result queue
    iphc_pkg::t_out_item r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_head, r_tail;
    logic [QPTR_W:0]     r_cnt;

    logic                in_fire, out_fire;
    logic                pay_hit, is_last;
    logic [15:0]         pos, rx_len;
    logic [5:0]          low_edge;
    logic [16:0]         sum_wide;
    logic [2:0]          verdict;
    logic [31:0]         dst_addr;
    iphc_pkg::t_out_item pay_item, ver_item, push0, push1;
    logic [1:0]          n_push;

    assign o_in_ready  = (r_cnt <= (QPTR_W+1)'(QDEPTH - 2));
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_q[r_head];

    assign pos     = r_byte_count;
    assign is_last = i_in_data.final_byte;

    // Next header state for the byte on the input
    always_comb begin
        n_hdr       = r_hdr;
        n_hdr_len   = r_hdr_len;
        n_total_len = r_total_len;
        n_csum      = r_csum;
        n_hold      = r_hold;
        n_sum       = r_sum;
        sum_wide    = '0;
        if (pos < 16'(iphc_pkg::BASE_HEADER)) begin
            n_hdr[pos[iphc_pkg::HDR_IDX_W-1:0]] = i_in_data.packet_byte;
        end
        if (pos == iphc_pkg::POS_VER_IHL) begin
            n_hdr_len = {i_in_data.packet_byte[3:0], 2'b00};
        end
        if (pos == iphc_pkg::POS_TLEN_LO) begin
            n_total_len = {r_hdr[iphc_pkg::POS_TLEN_HI], i_in_data.packet_byte};
        end
        if (pos == iphc_pkg::POS_CSUM_HI) begin
            n_csum = {i_in_data.packet_byte, 8'h00};
        end
        if (pos == iphc_pkg::POS_CSUM_LO) begin
            n_csum = {r_csum[15:8], i_in_data.packet_byte};
        end
        // Fold header words into the ones-complement sum; checksum word counts as zero
        if (pos < {10'd0, n_hdr_len} && pos < 16'(iphc_pkg::MAX_HEADER_BYTES)) begin
            if (!pos[0]) begin
                n_hold = i_in_data.packet_byte;
            end else if (pos != iphc_pkg::POS_CSUM_LO) begin
                sum_wide = {1'b0, r_sum} + {1'b0, r_hold, i_in_data.packet_byte};
                n_sum    = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end
    end

    // Payload window and received length
    always_comb begin
        low_edge = (n_hdr_len > 6'(iphc_pkg::BASE_HEADER)) ? n_hdr_len
                                                          : 6'(iphc_pkg::BASE_HEADER);
        pay_hit  = (pos >= {10'd0, low_edge}) && (pos < n_total_len);
        rx_len   = (pos != iphc_pkg::COUNT_MAX) ? pos + 16'd1 : pos;
    end

    // Verdict, checked in priority order
    always_comb begin
        dst_addr = {n_hdr[iphc_pkg::POS_DST],     n_hdr[iphc_pkg::POS_DST + 1],
                    n_hdr[iphc_pkg::POS_DST + 2], n_hdr[iphc_pkg::POS_DST + 3]};
        priority if (rx_len < 16'(iphc_pkg::BASE_HEADER)) begin
            verdict = iphc_pkg::VERDICT_SHORT;
        end else if (n_hdr[0][7:4] != iphc_pkg::IPV4_VER_CODE ||
                     n_total_len > rx_len ||
                     n_hdr_len < 6'(iphc_pkg::BASE_HEADER) ||
                     {10'd0, n_hdr_len} > n_total_len) begin
            verdict = iphc_pkg::VERDICT_BAD_HDR;
        end else if (~n_sum != n_csum) begin
            verdict = iphc_pkg::VERDICT_BAD_CSUM;
        end else if (dst_addr != r_local_addr) begin
            verdict = iphc_pkg::VERDICT_NOT_OURS;
        end else begin
            verdict = iphc_pkg::VERDICT_ACCEPT;
        end
    end

    // Build result items
    always_comb begin
        pay_item              = '0;
        pay_item.kind         = iphc_pkg::KIND_PAYLOAD;
        pay_item.payload_byte = i_in_data.packet_byte;

        ver_item              = '0;
        ver_item.kind         = iphc_pkg::KIND_VERDICT;
        ver_item.verdict      = verdict;
        ver_item.end_of_run   = 1'b1;
        if (verdict == iphc_pkg::VERDICT_ACCEPT) begin
            ver_item.upper_protocol = n_hdr[iphc_pkg::POS_PROTO];
            ver_item.source_address =
                {n_hdr[iphc_pkg::POS_SRC],     n_hdr[iphc_pkg::POS_SRC + 1],
                 n_hdr[iphc_pkg::POS_SRC + 2], n_hdr[iphc_pkg::POS_SRC + 3]};
        end

        // Payload goes first when both are pushed
        push0  = pay_hit ? pay_item : ver_item;
        push1  = ver_item;
        n_push = '0;
        if (in_fire) begin
            n_push = {1'b0, pay_hit} + {1'b0, is_last};
        end
    end

    // Advance or clear the packet state
    always_comb begin
        n_byte_count = r_byte_count;
        if (in_fire) begin
            n_byte_count = is_last ? '0 : rx_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_hdr_len    <= '0;
            r_total_len  <= '0;
            r_sum        <= '0;
            r_csum       <= '0;
            r_hold       <= '0;
            r_local_addr <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            if (in_fire) begin
                if (is_last) begin
                    r_hdr_len   <= '0;
                    r_total_len <= '0;
                    r_sum       <= '0;
                    r_csum      <= '0;
                    r_hold      <= '0;
                end else begin
                    r_hdr_len   <= n_hdr_len;
                    r_total_len <= n_total_len;
                    r_sum       <= n_sum;
                    r_csum      <= n_csum;
                    r_hold      <= n_hold;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_local_addr <= i_cfg_data;
            end
        end
    end

    // Header bytes hold no reset value
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hdr <= n_hdr;
        end
    end

    // Result queue: up to two pushes and one pop per cycle
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_q[r_tail] <= push0;
        end
        if (n_push == 2'd2) begin
            r_q[r_tail + QPTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= r_tail + QPTR_W'(n_push);
            if (out_fire) begin
                r_head <= r_head + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(n_push) - (QPTR_W+1)'(out_fire);
        end
    end

    // Checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH))
        else $error("result queue overfilled");

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && is_last |=> r_byte_count == '0)
        else $error("byte count not cleared after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !is_last && r_byte_count != iphc_pkg::COUNT_MAX
        |=> r_byte_count == $past(r_byte_count) + 16'd1)
        else $error("byte count did not advance");

    a_kind_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.kind == o_out_data.end_of_run)
        else $error("verdict item without end of run");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned REPORT_MAX = 10;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    iphc_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    iphc_pkg::t_out_item o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [31:0]         i_cfg_data = '0;

    ipv4_receive_header_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Bytes waiting for the link driver, and results the checker still owes us.
    iphc_pkg::t_in_item  wire_bytes[$];
    iphc_pkg::t_out_item expected_items[$];
    int unsigned bytes_queued = 0;
    int unsigned fail_count = 0;
    bit          no_idle = 1'b0;

    // Shadow copy of the checker's per-packet state and its local address.
    logic [31:0] local_addr_shadow = '0;
    logic [15:0] rx_count = '0;
    logic [7:0]  hdr_store [0:iphc_pkg::BASE_HEADER-1];
    logic [5:0]  hdr_len = '0;
    logic [15:0] tot_len = '0;
    logic [19:0] hdr_sum = '0;
    logic [15:0] csum_field = '0;
    logic [7:0]  hi_hold = '0;

    int unsigned in_gap = 0;
    int unsigned out_stall = 0;
    int unsigned idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    // Advance the shadow header state by one accepted byte and queue the results
    // that byte is owed: a payload item when it falls inside the payload window,
    // then a verdict item when it closes the packet.
    function automatic void track_header_byte(iphc_pkg::t_in_item it);
        logic [15:0] pos;
        logic [15:0] low_edge;
        logic [7:0]  b;
        iphc_pkg::t_out_item res;
        pos = rx_count;
        b = it.packet_byte;

        if (pos < iphc_pkg::BASE_HEADER) begin
            hdr_store[pos] = b;
        end
        if (pos == iphc_pkg::POS_VER_IHL) begin
            hdr_len = {b[3:0], 2'b00};
        end
        if (pos == iphc_pkg::POS_TLEN_LO) begin
            tot_len = {hdr_store[iphc_pkg::POS_TLEN_HI], b};
        end
        if (pos == iphc_pkg::POS_CSUM_HI) begin
            csum_field = {b, 8'h00};
        end
        if (pos == iphc_pkg::POS_CSUM_LO) begin
            csum_field[7:0] = b;
        end

        // Ones-complement sum over the header words, skipping the checksum word;
        // fold the carry back in after every add.
        if (pos < hdr_len && pos < iphc_pkg::MAX_HEADER_BYTES) begin
            if (!pos[0]) begin
                hi_hold = b;
            end else if (pos != iphc_pkg::POS_CSUM_LO) begin
                hdr_sum = hdr_sum + {4'h0, hi_hold, b};
                if (hdr_sum > 20'h0FFFF) begin
                    hdr_sum = {4'h0, hdr_sum[15:0]} + {16'h0, hdr_sum[19:16]};
                end
            end
        end

        low_edge = (hdr_len > iphc_pkg::BASE_HEADER) ? 16'(hdr_len)
                                                     : 16'(iphc_pkg::BASE_HEADER);
        if (pos >= low_edge && pos < tot_len) begin
            res = '0;
            res.kind = iphc_pkg::KIND_PAYLOAD;
            res.payload_byte = b;
            expected_items.push_back(res);
        end

        // Saturate the received length.
        if (rx_count != iphc_pkg::COUNT_MAX) begin
            rx_count = rx_count + 16'd1;
        end

        if (it.final_byte) begin
            res = '0;
            res.kind = iphc_pkg::KIND_VERDICT;
            res.end_of_run = 1'b1;
            if (rx_count < iphc_pkg::BASE_HEADER) begin
                res.verdict = iphc_pkg::VERDICT_SHORT;
            end else if (hdr_store[iphc_pkg::POS_VER_IHL][7:4] != iphc_pkg::IPV4_VER_CODE ||
                         tot_len > rx_count || hdr_len < iphc_pkg::BASE_HEADER ||
                         16'(hdr_len) > tot_len) begin
                res.verdict = iphc_pkg::VERDICT_BAD_HDR;
            end else if ((~hdr_sum[15:0]) != csum_field) begin
                res.verdict = iphc_pkg::VERDICT_BAD_CSUM;
            end else if ({hdr_store[iphc_pkg::POS_DST], hdr_store[iphc_pkg::POS_DST+1],
                          hdr_store[iphc_pkg::POS_DST+2], hdr_store[iphc_pkg::POS_DST+3]}
                         != local_addr_shadow) begin
                res.verdict = iphc_pkg::VERDICT_NOT_OURS;
            end else begin
                res.verdict = iphc_pkg::VERDICT_ACCEPT;
                res.upper_protocol = hdr_store[iphc_pkg::POS_PROTO];
                res.source_address = {hdr_store[iphc_pkg::POS_SRC],
                                      hdr_store[iphc_pkg::POS_SRC+1],
                                      hdr_store[iphc_pkg::POS_SRC+2],
                                      hdr_store[iphc_pkg::POS_SRC+3]};
            end
            expected_items.push_back(res);
            rx_count = '0;
            hdr_len = '0;
            tot_len = '0;
            hdr_sum = '0;
            csum_field = '0;
            hi_hold = '0;
        end
    endfunction

    // Compare one delivered result against the oldest outstanding expectation.
    function automatic void check_result(iphc_pkg::t_out_item got);
        iphc_pkg::t_out_item want;
        if (expected_items.size() == 0) begin
            report_failure($sformatf("unexpected item kind=%0d byte=%02h verdict=%0d",
                                     got.kind, got.payload_byte, got.verdict));
            return;
        end
        want = expected_items.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.verdict !== want.verdict || got.upper_protocol !== want.upper_protocol ||
            got.source_address !== want.source_address ||
            got.end_of_run !== want.end_of_run) begin
            report_failure($sformatf(
                {"exp kind=%0d byte=%02h verdict=%0d proto=%02h src=%08h eor=%0d / ",
                 "got kind=%0d byte=%02h verdict=%0d proto=%02h src=%08h eor=%0d"},
                want.kind, want.payload_byte, want.verdict, want.upper_protocol,
                want.source_address, want.end_of_run, got.kind, got.payload_byte,
                got.verdict, got.upper_protocol, got.source_address, got.end_of_run));
        end
    endfunction

    // Build one packet image: header fields as given, random filler elsewhere,
    // the checksum right or deliberately broken, then queue the first rx_len
    // bytes with the end marker on the last one.
    task automatic queue_packet(input logic [3:0] version, input logic [3:0] ihl,
                                input int unsigned tot, input int unsigned rx_len,
                                input logic [7:0] proto, input logic [31:0] src,
                                input logic [31:0] dst, input bit good_csum);
        logic [7:0]  image[];
        logic [31:0] sum;
        logic [15:0] csum;
        iphc_pkg::t_in_item it;
        int unsigned span;
        span = (rx_len > iphc_pkg::MAX_HEADER_BYTES) ? rx_len : iphc_pkg::MAX_HEADER_BYTES;
        image = new[span];
        foreach (image[i]) begin
            image[i] = 8'($urandom);
        end
        image[0] = {version, ihl};
        image[2] = tot[15:8];
        image[3] = tot[7:0];
        image[9] = proto;
        image[10] = 8'h00;
        image[11] = 8'h00;
        for (int i = 0; i < 4; i++) begin
            image[iphc_pkg::POS_SRC + i] = src[31 - 8*i -: 8];
            image[iphc_pkg::POS_DST + i] = dst[31 - 8*i -: 8];
        end
        sum = '0;
        for (int i = 0; i < 4 * ihl; i += 2) begin
            sum = sum + {image[i], image[i+1]};
        end
        while (sum[31:16] != 0) begin
            sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
        end
        csum = ~sum[15:0];
        if (!good_csum) begin
            csum = csum ^ (16'h0001 << $urandom_range(0, 15));
        end
        image[10] = csum[15:8];
        image[11] = csum[7:0];
        for (int unsigned i = 0; i < rx_len; i++) begin
            it.packet_byte = image[i];
            it.final_byte = (i == rx_len - 1);
            wire_bytes.push_back(it);
        end
        bytes_queued += rx_len;
    endtask

    // Mostly well-formed packets with random content; the rest is noise:
    // random version and IHL, truncated or padded lengths, wrong destination.
    task automatic queue_random_packet();
        logic [3:0]  ihl;
        int unsigned tot;
        int unsigned rx;
        logic [31:0] dst;
        if ($urandom_range(0, 9) < 7) begin
            ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
            tot = 4 * ihl + $urandom_range(0, 16);
            rx = tot + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            if ($urandom_range(0, 9) == 0) begin
                rx = $urandom_range(1, tot);
            end
            dst = ($urandom_range(0, 4) == 0) ? $urandom : local_addr_shadow;
            queue_packet(iphc_pkg::IPV4_VER_CODE, ihl, tot, rx, 8'($urandom), $urandom,
                         dst, $urandom_range(0, 9) != 0);
        end else begin
            queue_packet(4'($urandom), 4'($urandom), $urandom_range(0, 80),
                         $urandom_range(1, 80), 8'($urandom), $urandom,
                         ($urandom_range(0, 1) == 0) ? local_addr_shadow : $urandom,
                         $urandom_range(0, 1) == 1);
        end
    endtask

    task automatic queue_random_bytes(input int unsigned count);
        int unsigned target;
        target = bytes_queued + count;
        while (bytes_queued < target) begin
            queue_random_packet();
        end
    endtask

    // Hold until every byte has been taken and every owed result delivered,
    // then let the pipeline settle.
    task automatic wait_idle();
        while (wire_bytes.size() != 0 || i_in_valid || expected_items.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_local_address(input logic [31:0] addr);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= addr;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        local_addr_shadow = addr;
    endtask

    // Link driver: predict on every accepted byte, then present the next one
    // from the queue unless an idle burst is running.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                track_header_byte(i_in_data);
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (wire_bytes.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                    in_gap = $urandom_range(1, 3) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data <= wire_bytes.pop_front();
                end
            end
        end
    end

    // Result monitor: check every delivered item, stall ready in short bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_result(o_out_data);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                out_stall = $urandom_range(1, 3) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] home;
        home = 32'h0A00_0001;
        for (int i = 0; i < iphc_pkg::BASE_HEADER; i++) begin
            hdr_store[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_local_address(home);

        // Directed packets: accepts, every verdict, the IHL and length corner
        // cases, padding, and field extremes.
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 28, 28, 8'd17, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd15, 72, 72, 8'd6, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 20, 20, 8'hFF, 32'hFFFF_FFFF, home,
                     1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 20, 20, 8'h00, 32'h0000_0000, home,
                     1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 30, 1, 8'd1, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 30, 19, 8'd1, $urandom, home, 1'b1);
        queue_packet(4'd6, 4'd5, 24, 24, 8'd17, $urandom, home, 1'b1);
        queue_packet(4'hF, 4'hF, 16'hFFFF, 60, 8'hFF, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 40, 30, 8'd17, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd0, 24, 24, 8'd17, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd4, 24, 24, 8'd17, $urandom, home, 1'b1);
        // header runs past the declared total length
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd15, 40, 60, 8'd17, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 0, 24, 8'd17, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 24, 24, 8'd17, $urandom, home, 1'b0);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 24, 24, 8'd17, $urandom, ~home, 1'b1);
        // trailing padding beyond the total length is dropped
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd5, 26, 34, 8'd58, $urandom, home, 1'b1);
        queue_packet(iphc_pkg::IPV4_VER_CODE, 4'd6, 24, 24, 8'd1, $urandom, home, 1'b1);
        queue_random_bytes(100);
        wait_idle();

        write_local_address(32'hFFFF_FFFF);
        queue_random_bytes(100);
        wait_idle();

        write_local_address(32'h0000_0000);
        queue_random_bytes(100);
        wait_idle();

        // Last stretch runs with both sides at full rate.
        no_idle = 1'b1;
        write_local_address($urandom);
        queue_random_bytes(100);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (expected_items.size() != 0) begin
            report_failure($sformatf("%0d expected items never arrived",
                                     expected_items.size()));
        end
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
